@@ src/i2c_blm_pkg.sv @@
// Package with request/result types, command codes and phase encoding for the I2C bit engine.
package i2c_blm_pkg;

  // One tick of input: optional command plus the sampled SDA level
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] write_byte;
    logic       sda_in;
  } i2c_req_t;

  // Pin levels and status after one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
  } i2c_res_t;

  // Command codes
  localparam logic [2:0] FuncStart = 3'd0;
  localparam logic [2:0] FuncStop  = 3'd1;
  localparam logic [2:0] FuncWrite = 3'd2;
  localparam logic [2:0] FuncRead  = 3'd3;
  localparam logic [2:0] FuncAck   = 3'd4;
  localparam logic [2:0] FuncNack  = 3'd5;

  // Bits per byte transfer
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Sequencer phases, one-hot
  typedef enum logic [12:0] {
    PhIdle = 13'b0000000000001,
    PhS1   = 13'b0000000000010,
    PhS2   = 13'b0000000000100,
    PhP1   = 13'b0000000001000,
    PhP2   = 13'b0000000010000,
    PhWlo  = 13'b0000000100000,
    PhWhi  = 13'b0000001000000,
    PhAlo  = 13'b0000010000000,
    PhAhi  = 13'b0000100000000,
    PhRlo  = 13'b0001000000000,
    PhRhi  = 13'b0010000000000,
    PhClo  = 13'b0100000000000,
    PhChi  = 13'b1000000000000
  } phase_e;

endpackage

@@ src/i2c_bit_level_master.sv @@
// Top level of the single-master I2C bit engine: input register, sequencer, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------
//  in      | request   | in_valid_i/in_stall_o | in_req_i  (i2c_req_t)
//  out     | result    | out_valid_o/out_stall_i | out_res_o (i2c_res_t)
//  cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_data_i (delay_ticks)
//
// One tick request per clock cycle unless the output stalls; each request
// yields one result, via the input register, then the sequencer step into the
// result register. The step is a command decode, or a counter decrement and
// phase decode. Reset puts the pins at SCL high, SDA driven high, delay 20
// ticks. A stalled result holds; the input register still takes a request
// while the result register is full only if it is itself empty.
module i2c_bit_level_master (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2c_blm_pkg::i2c_req_t in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2c_blm_pkg::i2c_res_t out_res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [15:0]           cfg_data_i
);
  import i2c_blm_pkg::*;

  // Pipeline registers
  logic     in_vld_q;
  i2c_req_t in_q;
  logic     out_vld_q;
  i2c_res_t out_q;
  logic     out_free;
  logic     step;

  // Sequencer state
  logic [15:0] delay_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] cnt_q, cnt_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic        ack_q, ack_d;
  logic [7:0]  hold_q, hold_d;
  logic        done;
  logic [15:0] wait_len;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_up;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign cfg_ready_o = 1'b1;

  assign wait_len = (delay_q == '0) ? 16'd1 : delay_q;
  assign bit_inc  = bit_q + 4'd1;
  assign shift_up = {shift_q[6:0], 1'b0};

  // One tick of the bit sequencer
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    ack_d   = ack_q;
    hold_d  = hold_q;
    done    = 1'b0;
    if (phase_q == PhIdle) begin
      if (in_q.cmd_valid) begin
        case (in_q.func)
          FuncStart: begin
            sda_d = 1'b1; scl_d = 1'b1; drv_d = 1'b1;
            phase_d = PhS1; cnt_d = wait_len;
          end
          FuncStop: begin
            drv_d = 1'b1; sda_d = 1'b0;
            phase_d = PhP1; cnt_d = wait_len;
          end
          FuncWrite: begin
            drv_d = 1'b1; shift_d = in_q.write_byte; bit_d = '0;
            sda_d = in_q.write_byte[7];
            phase_d = PhWlo; cnt_d = wait_len;
          end
          FuncRead: begin
            drv_d = 1'b0; shift_d = '0; bit_d = '0;
            phase_d = PhRlo; cnt_d = wait_len;
          end
          FuncAck, FuncNack: begin
            drv_d = 1'b1; sda_d = (in_q.func == FuncNack);
            phase_d = PhClo; cnt_d = wait_len;
          end
          default: ;  // undefined codes leave the engine idle
        endcase
      end
    end else begin
      cnt_d = cnt_q - 16'd1;
      if (cnt_d == '0) begin
        unique case (phase_q)
          PhS1: begin sda_d = 1'b0; phase_d = PhS2; cnt_d = wait_len; end
          PhS2: begin scl_d = 1'b0; phase_d = PhIdle; done = 1'b1; end
          PhP1: begin scl_d = 1'b1; phase_d = PhP2; cnt_d = wait_len; end
          PhP2: begin sda_d = 1'b1; phase_d = PhIdle; done = 1'b1; end
          PhWlo: begin scl_d = 1'b1; phase_d = PhWhi; cnt_d = wait_len; end
          PhWhi: begin
            scl_d = 1'b0; shift_d = shift_up; bit_d = bit_inc; cnt_d = wait_len;
            if (bit_inc < BitsPerByte) begin
              sda_d = shift_up[7]; phase_d = PhWlo;
            end else begin
              drv_d = 1'b0; phase_d = PhAlo;
            end
          end
          PhAlo: begin scl_d = 1'b1; phase_d = PhAhi; cnt_d = wait_len; end
          PhAhi: begin
            ack_d = !in_q.sda_in; scl_d = 1'b0; phase_d = PhIdle; done = 1'b1;
          end
          PhRlo: begin scl_d = 1'b1; phase_d = PhRhi; cnt_d = wait_len; end
          PhRhi: begin
            shift_d = {shift_q[6:0], in_q.sda_in}; scl_d = 1'b0; bit_d = bit_inc;
            if (bit_inc < BitsPerByte) begin
              phase_d = PhRlo; cnt_d = wait_len;
            end else begin
              hold_d = {shift_q[6:0], in_q.sda_in}; phase_d = PhIdle; done = 1'b1;
            end
          end
          PhClo: begin scl_d = 1'b1; phase_d = PhChi; cnt_d = wait_len; end
          PhChi: begin scl_d = 1'b0; phase_d = PhIdle; done = 1'b1; end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_req_i;
    end
  end

  // Sequencer state and delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= 16'd20;
      phase_q <= PhIdle;
      bit_q   <= '0;
      shift_q <= '0;
      cnt_q   <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
      ack_q   <= 1'b0;
      hold_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        delay_q <= cfg_data_i;
      end
      if (step) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        cnt_q   <= cnt_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        drv_q   <= drv_d;
        ack_q   <= ack_d;
        hold_q  <= hold_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.scl_out      <= scl_d;
      out_q.sda_out      <= sda_d;
      out_q.sda_drive    <= drv_d;
      out_q.busy_res     <= (phase_d != PhIdle);
      out_q.done_res     <= done;
      out_q.read_byte    <= hold_d;
      out_q.ack_received <= ack_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

@@ src/i2c_blm_checker.sv @@
// Port-level checker for the I2C bit engine and its bind to the top level.
module i2c_blm_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input i2c_blm_pkg::i2c_res_t out_res_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // Input stalls only while a result is waiting on a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A completing command is never reported busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> !out_res_o.busy_res)
    else $error("done while busy");

  // Only a stop ends with SCL high, and then SDA is driven high
  a_done_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |->
      !out_res_o.scl_out || (out_res_o.sda_out && out_res_o.sda_drive))
    else $error("bad pin levels at command end");

  // Write port takes a request, checked here for idle-time writes with no tick traffic
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && !in_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind i2c_bit_level_master i2c_blm_checker u_i2c_blm_checker (.*);
